[src/erc_pkg.sv]
package erc_pkg;

  localparam int unsigned HALF_BITS = 64;
  localparam int unsigned MAG_BITS  = 128;
  localparam int unsigned CNT_W     = $clog2(MAG_BITS + 1);

  typedef logic [MAG_BITS-1:0]  mag_t;
  typedef logic [HALF_BITS-1:0] half_t;
  typedef logic signed [1:0]    order_t;

  localparam order_t ORD_LT = 2'sb11;
  localparam order_t ORD_EQ = 2'sb00;
  localparam order_t ORD_GT = 2'sb01;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[src/erc_in_if.sv]
interface erc_in_if;
  logic           valid;
  logic           ready;
  logic           left_negative;
  erc_pkg::half_t left_num_low;
  erc_pkg::half_t left_num_high;
  erc_pkg::half_t left_den_low;
  erc_pkg::half_t left_den_high;
  logic           right_negative;
  erc_pkg::half_t right_num_low;
  erc_pkg::half_t right_num_high;
  erc_pkg::half_t right_den_low;
  erc_pkg::half_t right_den_high;

  modport source (
    output valid, left_negative, left_num_low, left_num_high, left_den_low, left_den_high,
    output right_negative, right_num_low, right_num_high, right_den_low, right_den_high,
    input  ready
  );
  modport sink (
    input  valid, left_negative, left_num_low, left_num_high, left_den_low, left_den_high,
    input  right_negative, right_num_low, right_num_high, right_den_low, right_den_high,
    output ready
  );
endinterface

[src/erc_out_if.sv]
interface erc_out_if;
  logic            valid;
  logic            ready;
  erc_pkg::order_t order;
  logic            invalid;

  modport source (output valid, order, invalid, input ready);
  modport sink (input valid, order, invalid, output ready);
endinterface

[src/erc_div.sv]
module erc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  erc_pkg::div_ctrl_t  ctrl_i,
  input  erc_pkg::mag_t       num_i,
  input  erc_pkg::mag_t       den_i,
  output erc_pkg::div_stat_t  stat_o,
  output erc_pkg::mag_t       quo_o,
  output erc_pkg::mag_t       rem_o
);

  logic [erc_pkg::CNT_W-1:0]  cnt_q;
  logic                       busy_q;
  logic                       done_q;
  erc_pkg::mag_t              nq_q;
  erc_pkg::mag_t              rem_q;
  erc_pkg::mag_t              den_q;

  logic [erc_pkg::MAG_BITS:0] shifted;
  logic [erc_pkg::MAG_BITS:0] diff;
  logic                       ge;

  always_comb begin
    shifted = {rem_q, nq_q[erc_pkg::MAG_BITS-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      nq_q   <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        nq_q   <= num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= erc_pkg::CNT_W'(erc_pkg::MAG_BITS);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        nq_q  <= {nq_q[erc_pkg::MAG_BITS-2:0], ge};
        rem_q <= ge ? diff[erc_pkg::MAG_BITS-1:0] : shifted[erc_pkg::MAG_BITS-1:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == erc_pkg::CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o       = nq_q;
  assign rem_o       = rem_q;

endmodule

[src/exact_rational_compare_top.sv]
// Compares two signed rationals exactly and returns their order and an invalid flag,
// one result word for each input word. A zero denominator on either side gives
// invalid set and order zero; a zero numerator counts as zero whatever its sign.
// Zero-denominator and differing-sign cases skip the divider and go straight to the
// done state. Otherwise the block expands both values as continued fractions, and
// each expansion step runs two divisions on one shared restoring divider that produces
// one quotient bit per cycle; the number of steps follows the continued-fraction length
// of the operands and can reach about 185 at 128 bits. The input is not ready while a
// comparison is in progress, and a new word may be taken while the previous result
// still waits at the output register.
module exact_rational_compare_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  erc_in_if.sink      in_i,
  erc_out_if.source   out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_A,
    S_DIV_B,
    S_DONE
  } state_e;

  function automatic erc_pkg::mag_t mag_of(erc_pkg::half_t hi, erc_pkg::half_t lo);
    logic [2*erc_pkg::HALF_BITS-1:0] w;
    w = {hi, lo};
    return w[erc_pkg::MAG_BITS-1:0];
  endfunction

  function automatic erc_pkg::order_t flip(erc_pkg::order_t o, logic neg);
    erc_pkg::order_t r;
    r = o;
    if (neg) begin
      case (o)
        erc_pkg::ORD_LT: r = erc_pkg::ORD_GT;
        erc_pkg::ORD_GT: r = erc_pkg::ORD_LT;
        default:         r = erc_pkg::ORD_EQ;
      endcase
    end
    return r;
  endfunction

  state_e             state_q;
  erc_pkg::mag_t      an_q, ad_q, bn_q, bd_q, aq_q, ar_q;
  logic               dir_neg_q;
  logic               start_q;
  logic               sel_q;
  erc_pkg::order_t    res_ord_q;
  logic               res_inv_q;
  logic               out_valid_q;
  erc_pkg::order_t    out_ord_q;
  logic               out_inv_q;

  erc_pkg::mag_t      in_an, in_ad, in_bn, in_bd;
  logic               in_aneg, in_bneg, in_bad;

  erc_pkg::div_ctrl_t div_ctrl;
  erc_pkg::div_stat_t div_stat;
  erc_pkg::mag_t      div_num, div_den, div_quo, div_rem;

  erc_pkg::order_t    base_ord;
  logic               decided;

  always_comb begin
    in_an   = mag_of(in_i.left_num_high, in_i.left_num_low);
    in_ad   = mag_of(in_i.left_den_high, in_i.left_den_low);
    in_bn   = mag_of(in_i.right_num_high, in_i.right_num_low);
    in_bd   = mag_of(in_i.right_den_high, in_i.right_den_low);
    in_aneg = in_i.left_negative && (in_an != '0);
    in_bneg = in_i.right_negative && (in_bn != '0);
    in_bad  = (in_ad == '0) || (in_bd == '0);
  end

  always_comb begin
    div_ctrl.start = start_q;
    div_num        = sel_q ? bn_q : an_q;
    div_den        = sel_q ? bd_q : ad_q;
  end

  erc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  always_comb begin
    decided  = 1'b1;
    base_ord = erc_pkg::ORD_EQ;
    if (aq_q != div_quo) begin
      base_ord = (aq_q < div_quo) ? erc_pkg::ORD_LT : erc_pkg::ORD_GT;
    end else if ((ar_q == '0) && (div_rem == '0)) begin
      base_ord = erc_pkg::ORD_EQ;
    end else if (ar_q == '0) begin
      base_ord = erc_pkg::ORD_LT;
    end else if (div_rem == '0) begin
      base_ord = erc_pkg::ORD_GT;
    end else begin
      decided = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      an_q        <= '0;
      ad_q        <= '0;
      bn_q        <= '0;
      bd_q        <= '0;
      aq_q        <= '0;
      ar_q        <= '0;
      dir_neg_q   <= 1'b0;
      start_q     <= 1'b0;
      sel_q       <= 1'b0;
      res_ord_q   <= erc_pkg::ORD_EQ;
      res_inv_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_ord_q   <= erc_pkg::ORD_EQ;
      out_inv_q   <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            if (in_bad) begin
              res_ord_q <= erc_pkg::ORD_EQ;
              res_inv_q <= 1'b1;
              state_q   <= S_DONE;
            end else if (in_aneg != in_bneg) begin
              res_ord_q <= in_aneg ? erc_pkg::ORD_LT : erc_pkg::ORD_GT;
              res_inv_q <= 1'b0;
              state_q   <= S_DONE;
            end else begin
              an_q      <= in_an;
              ad_q      <= in_ad;
              bn_q      <= in_bn;
              bd_q      <= in_bd;
              dir_neg_q <= in_aneg;
              res_inv_q <= 1'b0;
              sel_q     <= 1'b0;
              start_q   <= 1'b1;
              state_q   <= S_DIV_A;
            end
          end
        end
        S_DIV_A: begin
          if (div_stat.done) begin
            aq_q    <= div_quo;
            ar_q    <= div_rem;
            sel_q   <= 1'b1;
            start_q <= 1'b1;
            state_q <= S_DIV_B;
          end
        end
        S_DIV_B: begin
          if (div_stat.done) begin
            if (decided) begin
              res_ord_q <= flip(base_ord, dir_neg_q);
              state_q   <= S_DONE;
            end else begin
              an_q      <= ad_q;
              ad_q      <= ar_q;
              bn_q      <= bd_q;
              bd_q      <= div_rem;
              dir_neg_q <= !dir_neg_q;
              sel_q     <= 1'b0;
              start_q   <= 1'b1;
              state_q   <= S_DIV_A;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_ord_q   <= res_ord_q;
            out_inv_q   <= res_inv_q;
            state_q     <= S_IDLE;
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.order   = out_ord_q;
  assign out_o.invalid = out_inv_q;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import erc_pkg::*;

  typedef logic [127:0] u128_t;

  typedef struct {
    logic  left_negative;
    half_t left_num_low;
    half_t left_num_high;
    half_t left_den_low;
    half_t left_den_high;
    logic  right_negative;
    half_t right_num_low;
    half_t right_num_high;
    half_t right_den_low;
    half_t right_den_high;
    int    gap;
    logic  drain;
  } cmp_word_t;

  typedef struct {
    order_t ord;
    logic   inv;
  } cmp_result_t;

  localparam int  STEP_CYCLES = 2 * (MAG_BITS + 2);
  localparam int  LONG_HOLD   = 5000;
  localparam int  TAIL_CYCLES = STEP_CYCLES + 40;
  localparam int  RANDOM_WORDS = 600;

  logic clk_i;
  logic rst_ni;

  erc_in_if  in_if ();
  erc_out_if out_if ();

  exact_rational_compare_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cmp_word_t   pending_words[$];
  cmp_result_t expected_orders[$];
  cmp_word_t   tx_cur;
  cmp_result_t exp_new;
  cmp_result_t got_expected;
  int          tx_wait;
  int          rx_wait;
  int          new_steps;
  int          word_total;
  int          words_sent;
  int          results_seen;
  int          mismatch_count;
  int          invalid_seen;
  int          sign_decided;
  int          expanded;
  int          deepest;
  longint      est_cycles;
  longint      cycle_limit;
  longint      cycle_count;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Exact order of the two values by continued-fraction expansion.
  function automatic void predict_order(input cmp_word_t w, output order_t ord,
                                        output logic inv, output int steps);
    mag_t an, ad, bn, bd, aq, ar, bq, br;
    logic a_neg, b_neg;
    int   dir;
    an = mag_t'({w.left_num_high, w.left_num_low});
    ad = mag_t'({w.left_den_high, w.left_den_low});
    bn = mag_t'({w.right_num_high, w.right_num_low});
    bd = mag_t'({w.right_den_high, w.right_den_low});
    ord = ORD_EQ;
    inv = 1'b0;
    steps = 0;
    if (ad == '0 || bd == '0) begin
      inv = 1'b1;
      return;
    end
    a_neg = w.left_negative && (an != '0);
    b_neg = w.right_negative && (bn != '0);
    if (a_neg != b_neg) begin
      ord = a_neg ? ORD_LT : ORD_GT;
      return;
    end
    dir = a_neg ? -1 : 1;
    while (1'b1) begin
      steps++;
      aq = an / ad;
      ar = an % ad;
      bq = bn / bd;
      br = bn % bd;
      if (aq != bq) begin
        ord = ((aq < bq) == (dir > 0)) ? ORD_LT : ORD_GT;
        return;
      end
      if (ar == '0 || br == '0) begin
        if (ar == '0 && br == '0) ord = ORD_EQ;
        else ord = ((ar == '0) == (dir > 0)) ? ORD_LT : ORD_GT;
        return;
      end
      an = ad;
      ad = ar;
      bn = bd;
      bd = br;
      dir = -dir;
    end
  endfunction

  function automatic u128_t rand_wide(input int bits);
    u128_t v;
    v = {$urandom, $urandom, $urandom, $urandom};
    if (bits <= 0) return '0;
    if (bits < 128) v = v & ((u128_t'(1) << bits) - 1);
    return v;
  endfunction

  function automatic u128_t rand_nz(input int bits);
    u128_t v;
    v = rand_wide(bits);
    if (v == '0) v = u128_t'(1);
    return v;
  endfunction

  function automatic int rand_width();
    return ($urandom_range(0, 1) == 0) ? 128 : $urandom_range(1, 128);
  endfunction

  function automatic cmp_word_t make_word(input logic ln, input u128_t lnum, input u128_t lden,
                                          input logic rn, input u128_t rnum, input u128_t rden);
    cmp_word_t w;
    w.left_negative  = ln;
    w.left_num_low   = lnum[63:0];
    w.left_num_high  = lnum[127:64];
    w.left_den_low   = lden[63:0];
    w.left_den_high  = lden[127:64];
    w.right_negative = rn;
    w.right_num_low  = rnum[63:0];
    w.right_num_high = rnum[127:64];
    w.right_den_low  = rden[63:0];
    w.right_den_high = rden[127:64];
    w.gap   = 0;
    w.drain = 1'b0;
    return w;
  endfunction

  task automatic enqueue_word(input cmp_word_t w);
    order_t o;
    logic   inv;
    int     steps;
    predict_order(w, o, inv, steps);
    w.gap   = ((word_total % 150) < 30) ? 0 : $urandom_range(0, 7);
    w.drain = (word_total == 200 || word_total == 480);
    pending_words.push_back(w);
    est_cycles += 40 + steps * STEP_CYCLES;
    word_total++;
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic build_stimulus();
    u128_t ones, fa, fb, fc, a, b, k1, k2, t;
    logic  s;
    int    sel;
    ones = '1;
    fa = 0;
    fb = 1;
    fc = 0;
    for (int i = 0; i < 185; i++) begin
      fc = fa;
      t  = fa + fb;
      fa = fb;
      fb = t;
    end
    // fc, fa, fb now hold three consecutive Fibonacci numbers, the largest that fit.
    enqueue_word(make_word(0, 5, 0, 0, 5, 1));
    enqueue_word(make_word(1, 7, 3, 0, 2, 0));
    enqueue_word(make_word(1, ones, 0, 1, ones, 0));
    enqueue_word(make_word(0, ones, ones, 0, ones, ones));
    enqueue_word(make_word(1, ones, 1, 0, ones, 1));
    enqueue_word(make_word(0, 1, ones, 1, 1, ones));
    enqueue_word(make_word(1, 0, 5, 0, 0, 9));
    enqueue_word(make_word(1, 0, 1, 0, 1, ones));
    enqueue_word(make_word(1, 1, 2, 1, 1, 3));
    enqueue_word(make_word(0, 2, 4, 0, 1, 2));
    enqueue_word(make_word(0, 3, 2, 0, 3, 1));
    enqueue_word(make_word(0, 2, 1, 0, 5, 2));
    enqueue_word(make_word(0, 5, 2, 0, 2, 1));
    enqueue_word(make_word(0, 7, 5, 0, 4, 3));
    enqueue_word(make_word(1, 7, 5, 1, 4, 3));
    enqueue_word(make_word(0, ones, 1, 0, ones - 1, 1));
    enqueue_word(make_word(0, 1, ones, 0, 1, ones - 1));
    enqueue_word(make_word(0, u128_t'(1) << 64, u128_t'(1) << 64, 0, 1, 1));
    enqueue_word(make_word(0, {{16{4'hA}}, {16{4'h5}}}, {{16{4'h5}}, {16{4'hA}}},
                           1, {{16{4'h5}}, {16{4'hA}}}, {{16{4'hA}}, {16{4'h5}}}));
    enqueue_word(make_word(0, fb, fa, 0, fb, fa));
    enqueue_word(make_word(0, fb, fa, 0, fa, fc));
    enqueue_word(make_word(0, 1, 3, 0, 0, 1));
    enqueue_word(make_word(0, {64'd0, {64{1'b1}}}, 1, 0, u128_t'(1) << 64, 1));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      s = 1'($urandom_range(0, 1));
      if (sel < 8) begin
        a = u128_t'($urandom_range(0, 2));
        enqueue_word(make_word(1'($urandom_range(0, 1)), rand_wide(rand_width()),
                               (a == 1) ? u128_t'(0) : rand_nz(rand_width()),
                               1'($urandom_range(0, 1)), rand_wide(rand_width()),
                               (a == 0) ? u128_t'(0) : rand_nz(rand_width())));
      end else if (sel < 16) begin
        a = u128_t'($urandom_range(0, 2));
        enqueue_word(make_word(1'($urandom_range(0, 1)),
                               (a == 1) ? rand_nz(rand_width()) : u128_t'(0),
                               rand_nz(rand_width()), 1'($urandom_range(0, 1)),
                               (a == 0) ? rand_nz(rand_width()) : u128_t'(0),
                               rand_nz(rand_width())));
      end else if (sel < 28) begin
        enqueue_word(make_word(s, rand_nz(rand_width()), rand_nz(rand_width()),
                               !s, rand_nz(rand_width()), rand_nz(rand_width())));
      end else if (sel < 53) begin
        a  = rand_nz($urandom_range(1, 16));
        b  = rand_nz($urandom_range(1, 16));
        k1 = rand_nz($urandom_range(1, 112));
        k2 = rand_nz($urandom_range(1, 112));
        if (sel < 43) begin
          enqueue_word(make_word(s, a * k1, b * k1, s, a * k2, b * k2));
        end else if ($urandom_range(0, 1) == 0) begin
          enqueue_word(make_word(s, a * k1, b * k1, s, a * k1 + 1, b * k1));
        end else begin
          enqueue_word(make_word(s, a * k1 - 1, b * k1, s, a, b));
        end
      end else begin
        enqueue_word(make_word(1'($urandom_range(0, 1)), rand_wide(rand_width()),
                               rand_nz(rand_width()), 1'($urandom_range(0, 1)),
                               rand_wide(rand_width()), rand_nz(rand_width())));
      end
    end
  endtask

  // Sender: offers queued words after drawn gaps; drain words wait for results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_order(tx_cur, exp_new.ord, exp_new.inv, new_steps);
        expected_orders.push_back(exp_new);
        words_sent++;
        if (exp_new.inv) invalid_seen++;
        else if (new_steps == 0) sign_decided++;
        else expanded++;
        if (new_steps > deepest) deepest = new_steps;
      end
      if (in_if.valid && !in_if.ready) begin
      end else if (pending_words.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pending_words[0].drain && expected_orders.size() != 0) begin
        in_if.valid <= 1'b0;
      end else if (tx_wait < pending_words[0].gap) begin
        tx_wait = tx_wait + 1;
        in_if.valid <= 1'b0;
      end else begin
        tx_cur = pending_words.pop_front();
        tx_wait = 0;
        in_if.left_negative  <= tx_cur.left_negative;
        in_if.left_num_low   <= tx_cur.left_num_low;
        in_if.left_num_high  <= tx_cur.left_num_high;
        in_if.left_den_low   <= tx_cur.left_den_low;
        in_if.left_den_high  <= tx_cur.left_den_high;
        in_if.right_negative <= tx_cur.right_negative;
        in_if.right_num_low  <= tx_cur.right_num_low;
        in_if.right_num_high <= tx_cur.right_num_high;
        in_if.right_den_low  <= tx_cur.right_den_low;
        in_if.right_den_high <= tx_cur.right_den_high;
        in_if.valid <= 1'b1;
      end
    end
  end

  // Receiver: checks each result word and stalls at random, with two long holds.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_orders.size() == 0) begin
          report_mismatch($sformatf("result order=%0d invalid=%b with nothing expected",
                                    out_if.order, out_if.invalid));
        end else begin
          got_expected = expected_orders.pop_front();
          if (out_if.order !== got_expected.ord)
            report_mismatch($sformatf("result %0d order got %0d expected %0d", results_seen,
                                      out_if.order, got_expected.ord));
          if (out_if.invalid !== got_expected.inv)
            report_mismatch($sformatf("result %0d invalid got %b expected %b", results_seen,
                                      out_if.invalid, got_expected.inv));
        end
        results_seen++;
        if (results_seen == 150 || results_seen == 450) rx_wait = LONG_HOLD;
        else if ((results_seen % 250) < 50) rx_wait = 0;
        else rx_wait = $urandom_range(0, 7);
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      out_if.ready <= (rx_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_limit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_orders.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.left_negative = 1'b0;
    in_if.left_num_low = '0;
    in_if.left_num_high = '0;
    in_if.left_den_low = '0;
    in_if.left_den_high = '0;
    in_if.right_negative = 1'b0;
    in_if.right_num_low = '0;
    in_if.right_num_high = '0;
    in_if.right_den_low = '0;
    in_if.right_den_high = '0;
    out_if.ready = 1'b0;
    cycle_count = 0;
    word_total = 0;
    words_sent = 0;
    results_seen = 0;
    mismatch_count = 0;
    invalid_seen = 0;
    sign_decided = 0;
    expanded = 0;
    deepest = 0;
    est_cycles = 0;
    build_stimulus();
    cycle_limit = 4 * est_cycles + 8 * LONG_HOLD + 20000;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_words.size() != 0 || in_if.valid || expected_orders.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Compared %0d results from %0d words: %0d with a zero denominator, %0d settled",
             results_seen, words_sent, invalid_seen, sign_decided);
    $display("by sign, %0d by continued-fraction expansion, deepest expansion %0d steps.",
             expanded, deepest);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
